[rtl/core/bfa_pkg.sv]
// Shared types and constants of the first-fit id allocator.
// Transfer structs, status and kind codes, and the owner-id selection function.
// No dependencies.
`default_nettype none

package bfa_pkg;

  // Fixed field widths
  localparam int KIND_W  = 1;
  localparam int BYTES_W = 13;
  localparam int INDEX_W = 10;
  localparam int ID_W    = 8;
  localparam int COUNT_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } bfa_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_UNOWNED = 2'd2
  } bfa_status_e;

  // One input transfer
  typedef struct packed {
    bfa_kind_e          kind;
    logic [BYTES_W-1:0] request_bytes;
    logic [INDEX_W-1:0] free_index;
  } bfa_in_t;

  // One result transfer
  typedef struct packed {
    bfa_status_e        status;
    logic [INDEX_W-1:0] start_unit;
    logic [ID_W-1:0]    run_id;
    logic [COUNT_W-1:0] unit_count;
    logic [COUNT_W-1:0] used_units;
  } bfa_out_t;

  // Next id after the left neighbor, skipping zero and the right neighbor's id.
  function automatic logic [ID_W-1:0] fresh_id(input logic [ID_W-1:0] left,
                                               input logic [ID_W-1:0] right);
    logic [ID_W-1:0] c;
    c = left + ID_W'(1);
    if (c == '0) c = ID_W'(1);
    if (c == right) c = c + ID_W'(1);
    if (c == '0) c = ID_W'(1);
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bfa_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/bitmap_id_first_fit_allocator_unit.sv]
// Top level of the first-fit id allocator: control sequencer around the owner RAM.
// Depends on bfa_pkg and bfa_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request per
//   transfer: allocate request_bytes (rounded up to UNIT_BYTES units) or free the
//   run at free_index. Output channel (out_valid_o / out_stall_i / out_data_o)
//   returns exactly one result per request, in order.
//   Allocate: the first read is issued, units are scanned from unit 0 up to the end
//   of the granted run, the right neighbor is read unless the run ends at the last
//   unit, each unit of the run is written, and the result goes to the output
//   register; a zero-length request goes straight to the output register.
//   Free: the owner at free_index is looked up and each unit of the run is cleared.
//   The single owner RAM port pair allows one read and one write per cycle.
//   After reset the owner RAM is swept to zero, one unit per cycle; in_stall_o
//   stays high until the sweep ends.
//   A finished result sits in an output register; a new request is taken while
//   it waits. If the receiver still stalls when the next result is ready, the
//   block holds that result and keeps in_stall_o high until the register frees.
`default_nettype none

module bitmap_id_first_fit_allocator_unit #(
  parameter int SLOTS      = 1024,
  parameter int UNIT_BYTES = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire bfa_pkg::bfa_in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output bfa_pkg::bfa_out_t     out_data_o
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
  localparam logic [bfa_pkg::BYTES_W-1:0] UB = bfa_pkg::BYTES_W'(UNIT_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_A_SCAN  = 8'b0000_0100,
    S_A_RIGHT = 8'b0000_1000,
    S_A_WRITE = 8'b0001_0000,
    S_F_LOOK  = 8'b0010_0000,
    S_F_CLEAR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]               x_q, x_d;
  logic [AW-1:0]               run_start_q, run_start_d;
  logic [AW-1:0]               run_end_q, run_end_d;
  logic [bfa_pkg::BYTES_W-1:0] bytes_q, bytes_d;
  logic [bfa_pkg::BYTES_W-1:0] rem_q, rem_d;
  logic [bfa_pkg::ID_W-1:0]    last_id_q, last_id_d;
  logic [bfa_pkg::ID_W-1:0]    id_q, id_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [CW-1:0]               used_q, used_d;
  bfa_pkg::bfa_out_t           res_q, res_d;
  bfa_pkg::bfa_out_t           out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  // Owner RAM ports
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [bfa_pkg::ID_W-1:0]    ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [bfa_pkg::ID_W-1:0]    ram_rdata;

  bfa_ram #(
    .WIDTH (bfa_pkg::ID_W),
    .DEPTH (SLOTS)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer: reset sweep, scan, neighbor read, run write, owner lookup, run clear, hand-off
  always_comb begin
    logic [AW-1:0] rd_next;
    logic [CW-1:0] c_fin;
    logic [SW-1:0] sum;

    rd_next = (x_q == LAST) ? '0 : x_q + AW'(1);
    c_fin   = cnt_q;
    sum     = '0;

    state_d     = state_q;
    x_d         = x_q;
    run_start_d = run_start_q;
    run_end_d   = run_end_q;
    bytes_d     = bytes_q;
    rem_d       = rem_q;
    last_id_d   = last_id_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    ram_we    = 1'b0;
    ram_waddr = x_q;
    ram_wdata = '0;
    ram_raddr = rd_next;

    case (state_q)
      // Post-reset sweep of the owner RAM
      S_CLEAR: begin
        ram_we = 1'b1;
        if (x_q == LAST) begin
          x_d     = '0;
          state_d = S_IDLE;
        end else begin
          x_d = rd_next;
        end
      end

      S_IDLE: begin
        ram_raddr = '0;
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.kind == bfa_pkg::KIND_ALLOC) begin
            bytes_d     = in_data_i.request_bytes;
            rem_d       = in_data_i.request_bytes;
            run_start_d = '0;
            last_id_d   = '0;
            x_d         = '0;
            if (in_data_i.request_bytes == '0) begin
              res_d.status = bfa_pkg::ST_OK;
              state_d      = S_DONE;
            end else begin
              state_d = S_A_SCAN;
            end
          end else begin
            if (32'(in_data_i.free_index) >= 32'(SLOTS)) begin
              res_d.status     = bfa_pkg::ST_UNOWNED;
              res_d.start_unit = in_data_i.free_index;
              state_d          = S_DONE;
            end else begin
              ram_raddr = AW'(in_data_i.free_index);
              x_d       = AW'(in_data_i.free_index);
              state_d   = S_F_LOOK;
            end
          end
        end
      end

      // One unit per cycle; data for x_q arrives, x_q+1 is being read
      S_A_SCAN: begin
        if (ram_rdata == '0) begin
          if (rem_q <= UB) begin
            run_end_d = x_q;
            cnt_d     = CW'(x_q - run_start_q) + CW'(1);
            if (x_q == LAST) begin
              id_d    = bfa_pkg::fresh_id(last_id_q, '0);
              x_d     = run_start_q;
              state_d = S_A_WRITE;
            end else begin
              state_d = S_A_RIGHT;
            end
          end else begin
            rem_d = rem_q - UB;
            if (x_q == LAST) begin
              res_d.status = bfa_pkg::ST_NOSPACE;
              state_d      = S_DONE;
            end else begin
              x_d = rd_next;
            end
          end
        end else begin
          rem_d       = bytes_q;
          last_id_d   = ram_rdata;
          run_start_d = rd_next;
          if (x_q == LAST) begin
            res_d.status = bfa_pkg::ST_NOSPACE;
            state_d      = S_DONE;
          end else begin
            x_d = rd_next;
          end
        end
      end

      // Right neighbor of the found run is on the read port
      S_A_RIGHT: begin
        id_d    = bfa_pkg::fresh_id(last_id_q, ram_rdata);
        x_d     = run_start_q;
        state_d = S_A_WRITE;
      end

      // Tag the run, one unit per cycle
      S_A_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = id_q;
        if (x_q == run_end_q) begin
          res_d.status     = bfa_pkg::ST_OK;
          res_d.start_unit = bfa_pkg::INDEX_W'(run_start_q);
          res_d.run_id     = id_q;
          res_d.unit_count = bfa_pkg::COUNT_W'(cnt_q);
          sum    = SW'(used_q) + SW'(cnt_q);
          used_d = (sum > SW'(SLOTS)) ? CW'(SLOTS) : CW'(sum);
          state_d = S_DONE;
        end else begin
          x_d = rd_next;
        end
      end

      // Owner of the freed index
      S_F_LOOK: begin
        if (ram_rdata == '0) begin
          res_d.status     = bfa_pkg::ST_UNOWNED;
          res_d.start_unit = bfa_pkg::INDEX_W'(x_q);
          state_d          = S_DONE;
        end else begin
          ram_we      = 1'b1;
          id_d        = ram_rdata;
          cnt_d       = CW'(1);
          run_start_d = x_q;
          if (x_q == LAST) begin
            res_d.status     = bfa_pkg::ST_OK;
            res_d.start_unit = bfa_pkg::INDEX_W'(x_q);
            res_d.run_id     = ram_rdata;
            res_d.unit_count = bfa_pkg::COUNT_W'(1);
            used_d  = (used_q >= CW'(1)) ? used_q - CW'(1) : '0;
            state_d = S_DONE;
          end else begin
            x_d     = rd_next;
            state_d = S_F_CLEAR;
          end
        end
      end

      // Clear upward while the id matches
      S_F_CLEAR: begin
        if (ram_rdata == id_q) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          c_fin  = cnt_q + CW'(1);
          if (x_q != LAST) begin
            x_d = rd_next;
          end
        end
        if ((ram_rdata != id_q) || (x_q == LAST)) begin
          res_d.status     = bfa_pkg::ST_OK;
          res_d.start_unit = bfa_pkg::INDEX_W'(run_start_q);
          res_d.run_id     = id_q;
          res_d.unit_count = bfa_pkg::COUNT_W'(c_fin);
          used_d  = (used_q >= c_fin) ? used_q - c_fin : '0;
          state_d = S_DONE;
        end
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d            = res_q;
          out_d.used_units = bfa_pkg::COUNT_W'(used_q);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      x_q         <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_start_q <= run_start_d;
    run_end_q   <= run_end_d;
    bytes_q     <= bytes_d;
    rem_q       <= rem_d;
    last_id_q   <= last_id_d;
    id_q        <= id_d;
    cnt_q       <= cnt_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(SLOTS))
    else $error("used counter above region size");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SCAN) |-> (run_start_q <= x_q))
    else $error("run start ahead of scan pointer");

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_WRITE) |-> ((x_q >= run_start_q) && (x_q <= run_end_q)))
    else $error("tag write outside granted run");

  a_only_alloc_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && (state_q != S_A_WRITE)) |-> (ram_wdata == '0))
    else $error("nonzero owner written outside allocation");

endmodule

`default_nettype wire

[bench/bfa_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the first-fit id allocator bench. It keeps its own copy of the
// owner table and used counter, predicts one result per request and checks results.
// Depends on bfa_pkg.
package bfa_tb_pkg;
  import bfa_pkg::*;

  localparam int TB_SLOTS      = 1024;
  localparam int TB_UNIT_BYTES = 4;

  class alloc_scoreboard;
    logic [ID_W-1:0] owner [TB_SLOTS];
    int unsigned     used;
    bfa_out_t        pending_results [$];
    int unsigned     errors;

    function new();
      foreach (owner[i]) owner[i] = '0;
      used   = 0;
      errors = 0;
    endfunction

    // First id after the left neighbor that is neither zero nor the right neighbor's id
    function logic [ID_W-1:0] next_run_id(logic [ID_W-1:0] left, logic [ID_W-1:0] right);
      logic [ID_W-1:0] c;
      c = left + ID_W'(1);
      while (c == right || c == '0) c = c + ID_W'(1);
      return c;
    endfunction

    // First-fit search from unit 0, then tag the run
    function bfa_out_t grant_run(logic [BYTES_W-1:0] bytes);
      bfa_out_t        res;
      int unsigned     need;
      int unsigned     x;
      int unsigned     y;
      int unsigned     z;
      logic [ID_W-1:0] left;
      logic [ID_W-1:0] right;
      logic [ID_W-1:0] id;
      bit              found;
      res    = '0;
      res.status = ST_OK;
      need   = (bytes + TB_UNIT_BYTES - 1) / TB_UNIT_BYTES;
      found  = 1'b0;
      x      = 0;
      if (need == 0) return res;
      if (need > TB_SLOTS) begin
        res.status = ST_NOSPACE;
        return res;
      end
      while (!found && x + need <= TB_SLOTS) begin
        y = 0;
        while (y < need && owner[x + y] == '0) y++;
        if (y == need) found = 1'b1;
        else x += y + 1;  // skip past the owned unit
      end
      if (!found) begin
        res.status = ST_NOSPACE;
        return res;
      end
      left  = (x > 0) ? owner[x - 1] : '0;
      right = (x + need < TB_SLOTS) ? owner[x + need] : '0;
      id    = next_run_id(left, right);
      for (z = 0; z < need; z++) owner[x + z] = id;
      used  = (used + need > TB_SLOTS) ? TB_SLOTS : used + need;
      res.start_unit = INDEX_W'(x);
      res.run_id     = id;
      res.unit_count = COUNT_W'(need);
      return res;
    endfunction

    // Clear the run of equal ids from the index upward
    function bfa_out_t release_run(logic [INDEX_W-1:0] idx);
      bfa_out_t        res;
      logic [ID_W-1:0] id;
      int unsigned     x;
      int unsigned     cnt;
      res            = '0;
      res.status     = ST_UNOWNED;
      res.start_unit = idx;
      cnt            = 0;
      if (idx >= TB_SLOTS || owner[idx] == '0) return res;
      id = owner[idx];
      for (x = idx; x < TB_SLOTS && owner[x] == id; x++) begin
        owner[x] = '0;
        cnt++;
      end
      used = (used >= cnt) ? used - cnt : 0;
      res.status     = ST_OK;
      res.run_id     = id;
      res.unit_count = COUNT_W'(cnt);
      return res;
    endfunction

    // Called on every accepted request transfer
    function void note_request(bfa_in_t req);
      bfa_out_t res;
      if (req.kind == KIND_ALLOC) res = grant_run(req.request_bytes);
      else res = release_run(req.free_index);
      res.used_units = COUNT_W'(used);
      pending_results.push_back(res);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Called on every accepted result transfer
    function void check_result(bfa_out_t got);
      bfa_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("start_unit", want.start_unit, got.start_unit);
      compare_field("run_id", want.run_id, got.run_id);
      compare_field("unit_count", want.unit_count, got.unit_count);
      compare_field("used_units", want.used_units, got.used_units);
    endfunction
  endclass

endpackage

[bench/tb_bitmap_id_first_fit_allocator_unit.sv]
`timescale 1ns / 100ps
// Top of the first-fit id allocator bench: clock, reset, request driver,
// result receiver, transfer monitor and watchdog.
// Depends on bfa_pkg, bfa_tb_pkg and bitmap_id_first_fit_allocator_unit.
module tb_bitmap_id_first_fit_allocator_unit;
  import bfa_pkg::*;
  import bfa_tb_pkg::*;

  localparam int LONG_HOLD      = 4000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 145;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  bfa_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  bfa_out_t out_data_o;

  alloc_scoreboard sb;
  bit              tx_quiet     = 1'b0;
  bit              rx_quiet     = 1'b0;
  bit              hold_off_req = 1'b0;
  int unsigned     idle_cycles  = 0;

  bitmap_id_first_fit_allocator_unit #(
    .SLOTS      (TB_SLOTS),
    .UNIT_BYTES (TB_UNIT_BYTES)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bfa_in_t alloc_req(logic [BYTES_W-1:0] bytes);
    bfa_in_t req;
    req.kind          = KIND_ALLOC;
    req.request_bytes = bytes;
    req.free_index    = INDEX_W'($urandom);
    return req;
  endfunction

  function automatic bfa_in_t free_req(logic [INDEX_W-1:0] idx);
    bfa_in_t req;
    req.kind          = KIND_FREE;
    req.request_bytes = BYTES_W'($urandom);
    req.free_index    = idx;
    return req;
  endfunction

  // Mostly small allocations and frees of live runs; some oversize and stray frees
  function automatic bfa_in_t random_request();
    int unsigned roll;
    int unsigned sub;
    int unsigned idx;
    int unsigned probe;
    bit          hit;
    roll = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    hit  = 1'b0;
    if (sb.used > 600 && roll >= 25 && roll < 50) roll += 25;
    if (roll < 50) begin
      if (sub < 4) return alloc_req('0);
      if (sub < 8) return alloc_req(BYTES_W'($urandom_range(4097, 8191)));
      if (sub < 18) return alloc_req(BYTES_W'($urandom_range(65, 4096)));
      return alloc_req(BYTES_W'($urandom_range(1, 64)));
    end
    idx = $urandom_range(0, TB_SLOTS - 1);
    if (sub < 15) return free_req(INDEX_W'(idx));
    // look for an owned unit, wrapping around the region
    for (probe = 0; probe < TB_SLOTS && !hit; probe++) begin
      if (sb.owner[idx] != '0) hit = 1'b1;
      else idx = (idx + 1) % TB_SLOTS;
    end
    if (hit && $urandom_range(0, 3) != 0) begin
      while (idx > 0 && sb.owner[idx - 1] == sb.owner[idx]) idx--;
    end
    return free_req(INDEX_W'(idx));
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_request(input bfa_in_t req);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  // Request side
  initial begin : stimulus
    int phase;
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of the region, rounding, oversize, stray frees, id collision
    send_request(alloc_req(13'd0));
    send_request(alloc_req(13'd4096));
    send_request(alloc_req(13'd1));
    send_request(free_req(10'd1023));
    send_request(alloc_req(13'd4));
    send_request(free_req(10'd0));
    send_request(free_req(10'd0));
    send_request(free_req(10'd1023));
    send_request(alloc_req(13'd8191));
    send_request(alloc_req(13'd4097));
    send_request(alloc_req(13'd4093));
    send_request(free_req(10'd0));
    send_request(alloc_req(13'd8));
    send_request(alloc_req(13'd4));
    send_request(alloc_req(13'd5));
    send_request(free_req(10'd1));
    send_request(alloc_req(13'd3));
    send_request(alloc_req(13'd12));
    send_request(free_req(10'd3));
    send_request(free_req(10'd512));
    send_request(alloc_req(13'd1));
    wait_for_drain();

    // Random phases with different idling on each side
    for (phase = 0; phase < 4; phase++) begin
      tx_quiet = (phase == 0 || phase == 2);
      rx_quiet = (phase == 0 || phase == 3);
      if (phase == 2) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request());
      wait_for_drain();
    end

    repeat (2 * TB_SLOTS + 16) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS bitmap_id_first_fit_allocator_unit");
    end else begin
      $display("FAIL bitmap_id_first_fit_allocator_unit");
    end
    $finish;
  end

  // Result side: random stall before each transfer, one long hold-off on request
  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = rx_quiet ? 0 : $urandom_range(0, 12);
      end
      out_stall_i <= (n != 0);
      if (n != 0) begin
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Transfer monitor and watchdog
  always @(posedge clk_i) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(in_data_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("FAIL bitmap_id_first_fit_allocator_unit");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bitmap_id_first_fit_allocator_unit.sv
bench/bfa_tb_pkg.sv
bench/tb_bitmap_id_first_fit_allocator_unit.sv
